// ===== sv/deq_pkg.sv =====
// Shared types, codes and defaults for the circular-buffer deque.
package deq_pkg;

	localparam int DEF_CAPACITY = 8;
	localparam int WORD_W       = 32;
	localparam int OCC_W        = 4;

	localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
	localparam logic [1:0] ACT_PUSH_BACK  = 2'd1;
	localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
	localparam logic [1:0] ACT_POP_BACK   = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               action;
		logic signed [WORD_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] popped_value;
		logic [OCC_W-1:0]         occupancy;
		logic                     is_full;
		logic                     is_empty;
	} rsp_t;

	// Everything of a result except the popped word, as held by the control stage.
	typedef struct packed {
		logic [1:0]       status;
		logic [OCC_W-1:0] occupancy;
		logic             is_full;
		logic             is_empty;
		logic             pop_ok;
	} stat_t;

endpackage

// ===== sv/deq_mem.sv =====
// Slot memory: one write port, one read port with registered read data.
module deq_mem #(
	parameter int CAPACITY = deq_pkg::DEF_CAPACITY,
	parameter int IW       = $clog2(CAPACITY)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [IW-1:0]             waddr,
	input  logic [deq_pkg::WORD_W-1:0] wdata,
	input  logic                      re,
	input  logic [IW-1:0]             raddr,
	output logic [deq_pkg::WORD_W-1:0] rdata
);

	logic [deq_pkg::WORD_W-1:0] mem_q [CAPACITY];
	logic [deq_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/deq_ctrl.sv =====
// Index and count control: decides each operation and drives the slot memory.
module deq_ctrl #(
	parameter int CAPACITY = deq_pkg::DEF_CAPACITY,
	parameter int IW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  deq_pkg::cmd_t              cmd,
	output logic                       we,
	output logic [IW-1:0]              waddr,
	output logic [deq_pkg::WORD_W-1:0] wdata,
	output logic                       re,
	output logic [IW-1:0]              raddr,
	output logic                       strobe_s1,
	output deq_pkg::stat_t             stat_s1
);

	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	logic [IW-1:0] head_q, tail_q, head_n, tail_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [IW-1:0] head_up, head_dn, tail_up, tail_dn;
	logic          is_push, push_ok, pop_ok;
	logic [1:0]    status_n;
	logic [CW+deq_pkg::OCC_W-1:0] occ_wide;
	deq_pkg::stat_t stat_n;

	assign head_up = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_dn = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_up = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_dn = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	assign is_push = cmd.action inside {deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK};
	assign push_ok = is_push && (cnt_q != FULL_CNT);
	assign pop_ok  = !is_push && (cnt_q != '0);

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		cnt_n    = cnt_q;
		status_n = deq_pkg::ST_DONE;
		we       = 1'b0;
		waddr    = '0;
		re       = 1'b0;
		raddr    = '0;
		if (is_push) begin
			if (!push_ok) begin
				status_n = deq_pkg::ST_FULL;
			end else begin
				we    = accept;
				cnt_n = cnt_q + 1'b1;
				if (cnt_q == '0) begin
					// empty: both ends restart at slot zero
					head_n = '0;
					tail_n = '0;
					waddr  = '0;
				end else if (cmd.action == deq_pkg::ACT_PUSH_FRONT) begin
					head_n = head_dn;
					waddr  = head_dn;
				end else begin
					tail_n = tail_up;
					waddr  = tail_up;
				end
			end
		end else begin
			if (!pop_ok) begin
				status_n = deq_pkg::ST_EMPTY;
			end else begin
				re    = accept;
				cnt_n = cnt_q - 1'b1;
				if (cmd.action == deq_pkg::ACT_POP_FRONT) begin
					raddr  = head_q;
					head_n = head_up;
				end else begin
					raddr  = tail_q;
					tail_n = tail_dn;
				end
				if (cnt_q == CW'(1)) begin
					head_n = '0;
					tail_n = '0;
				end
			end
		end
	end

	assign wdata    = cmd.push_value;
	assign occ_wide = (CW + deq_pkg::OCC_W)'(cnt_n);

	always_comb begin
		stat_n.status    = status_n;
		stat_n.occupancy = occ_wide[deq_pkg::OCC_W-1:0];
		stat_n.is_full   = (cnt_n == FULL_CNT);
		stat_n.is_empty  = (cnt_n == '0);
		stat_n.pop_ok    = pop_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= accept;
			if (accept) begin
				head_q <= head_n;
				tail_q <= tail_n;
				cnt_q  <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stat_s1 <= stat_n;
		end
	end

endmodule

// ===== sv/double_ended_queue_top.sv =====
// Top level of the circular-buffer deque of signed 32-bit words.
//
// A double-ended queue of CAPACITY signed words kept in a circular buffer.
// Raise start with a command on item: push front, push back, pop front or
// pop back. A command is taken at every rising edge where start is high and
// busy is low; busy stays low, so one command can be taken every cycle.
// Every command gives exactly one result beat on result, marked by
// result_strobe for one cycle, the cycle after the command was taken.
// The receiver cannot stall: sample the beat while the strobe is high.
// A push into a full deque reports status full and changes nothing; a pop
// from an empty deque reports status empty with a zero word. occupancy
// carries the low four bits of the count after the command, and is_full
// and is_empty flag the count against CAPACITY and zero.
// The result beat is registered, its word by the registered read port of the slot
// memory; the index and count registers update in the accept cycle, so the
// next command already sees them. No clearing pass is needed after reset:
// a slot is never read before it has been written.
module double_ended_queue_top #(
	parameter int CAPACITY = deq_pkg::DEF_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  deq_pkg::cmd_t item,
	output logic          result_strobe,
	output deq_pkg::rsp_t result
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic                       accept;
	logic                       we, re;
	logic [IW-1:0]              waddr, raddr;
	logic [deq_pkg::WORD_W-1:0] wdata, rdata;
	deq_pkg::stat_t             stat_s1;

	// never hold commands off: memory and indices keep pace every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	deq_ctrl #(
		.CAPACITY (CAPACITY),
		.IW       (IW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (item),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.strobe_s1 (result_strobe),
		.stat_s1   (stat_s1)
	);

	deq_mem #(
		.CAPACITY (CAPACITY),
		.IW       (IW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Assemble the result beat; drop the memory word unless a pop succeeded.
	always_comb begin
		result.status       = stat_s1.status;
		result.popped_value = stat_s1.pop_ok ? $signed(rdata) : '0;
		result.occupancy    = stat_s1.occupancy;
		result.is_full      = stat_s1.is_full;
		result.is_empty     = stat_s1.is_empty;
	end

endmodule
